@@ rtl/core/bss_pkg.sv @@
// Package for the bounded stack with search: operation codes, field widths
// and default sizes. No dependencies.
package bss_pkg;

    localparam int WORD_W      = 32;   // stored word and key width
    localparam int KIND_W      = 2;
    localparam int CAP_W       = 7;    // capacity register width
    localparam int IDX_W       = 7;    // found_index field width
    localparam int CNT_W       = 7;    // count field width
    localparam int DEPTH_DEF   = 64;
    localparam int CAP_RESET   = 64;
    localparam int OUT_DATA_W  = 88;   // 81 bits of result, padded to bytes

    localparam logic [IDX_W-1:0] NO_MATCH = {IDX_W{1'b1}};  // -1

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_FIND  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

endpackage

@@ rtl/core/bss_ram.sv @@
// Entry store of the stack: one write port, one read port with registered
// read data. Depends on bss_pkg for the default depth and word width.
module bss_ram #(
    parameter int DEPTH = bss_pkg::DEPTH_DEF,
    parameter int WIDTH = bss_pkg::WORD_W
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/bounded_stack_with_search_unit.sv @@
// Bounded stack of signed 32-bit words with a bottom-up linear search.
// Push, clear, a pop that empties or fails and a find on an empty stack go
// straight to ST_DONE; a pop that leaves entries reads the new top in ST_POPRD;
// find compares entries in ST_SCAN (at most the fill count, one store read a
// cycle) up to a match or the top. One request at a time; a stalled result
// holds the unit. Reset: count 0, capacity 64, no result; entries kept.
module bounded_stack_with_search_unit #(
    parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration: capacity
    input  logic                                  cfg_wr_en,
    input  logic [bss_pkg::CAP_W-1:0]             cfg_wr_data,
    // request stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [bss_pkg::WORD_W-1:0]            s_axis_tdata,  // [31:0] value
    input  logic [bss_pkg::KIND_W-1:0]            s_axis_tuser,  // [1:0] kind
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [0] ok, [7:1] found_index, [14:8] count, [46:15] top_value,
    // [78:47] bottom_value, [79] full_res, [80] empty_res, [87:81] zero
    output logic [bss_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

    import bss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // entry address
    localparam int CW = $clog2(DEPTH + 1);                 // fill count
    localparam int MW = (CW > CAP_W) ? CW : CAP_W;         // capacity compare

    // Sequencer: idle, wait for the new top after a pop, scan for find,
    // then hold until the result register is free.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_POPRD = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CAP_W-1:0]     capacity_reg;
    logic                 out_valid_reg, out_valid_next;

    // payload, no reset needed
    logic [WORD_W-1:0]    top_reg, top_next;
    logic [WORD_W-1:0]    bottom_reg, bottom_next;
    logic [WORD_W-1:0]    key_reg, key_next;
    logic [AW-1:0]        scan_reg, scan_next;
    logic                 ok_reg, ok_next;
    logic [IDX_W-1:0]     found_reg, found_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // entry store ports
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic                 ram_rd_en;
    logic [AW-1:0]        ram_rd_addr;
    logic [WORD_W-1:0]    ram_rd_data;

    // effective capacity is the register saturated to the built depth
    logic [MW-1:0]        cap_eff;
    logic [MW-1:0]        count_ext;
    logic                 full_now;
    logic                 empty_now;
    logic                 req_take;
    logic                 out_free;
    logic                 scan_last;

    bss_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign count_ext = MW'(count_reg);
    assign cap_eff   = (MW'(capacity_reg) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(capacity_reg);
    assign full_now  = (count_ext >= cap_eff);
    assign empty_now = (count_reg == '0);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign req_take      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign scan_last     = ((CW'(scan_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        top_next       = top_reg;
        bottom_next    = bottom_reg;
        key_next       = key_reg;
        scan_next      = scan_reg;
        ok_next        = ok_reg;
        found_next     = found_reg;
        out_data_next  = out_data_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = AW'(count_reg);
        ram_rd_en      = 1'b0;
        ram_rd_addr    = scan_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    key_next   = s_axis_tdata;
                    ok_next    = 1'b1;
                    found_next = NO_MATCH;
                    state_next = ST_DONE;
                    unique case (kind_t'(s_axis_tuser))
                        KIND_PUSH:
                        begin
                            if (!full_now)
                            begin
                                ram_wr_en  = 1'b1;
                                top_next   = s_axis_tdata;
                                if (empty_now)
                                begin
                                    bottom_next = s_axis_tdata;
                                end
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                ok_next = 1'b0;
                            end
                        end
                        KIND_POP:
                        begin
                            if (!empty_now)
                            begin
                                count_next = count_reg - CW'(1);
                                // two or more held: fetch the entry below the top
                                if (count_reg > CW'(1))
                                begin
                                    ram_rd_en   = 1'b1;
                                    ram_rd_addr = AW'(count_reg - CW'(2));
                                    state_next  = ST_POPRD;
                                end
                            end
                            else
                            begin
                                ok_next = 1'b0;
                            end
                        end
                        KIND_FIND:
                        begin
                            if (!empty_now)
                            begin
                                scan_next   = '0;
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                state_next  = ST_SCAN;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_POPRD:
            begin
                top_next   = ram_rd_data;
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                // ram_rd_data holds the entry at scan_reg
                if (ram_rd_data == key_reg)
                begin
                    found_next = IDX_W'(scan_reg);
                    state_next = ST_DONE;
                end
                else if (scan_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_next   = scan_reg + AW'(1);
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = scan_reg + AW'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_next = '0;
                    out_data_next[0]     = ok_reg;
                    out_data_next[7:1]   = found_reg;
                    out_data_next[14:8]  = CNT_W'(count_reg);
                    out_data_next[46:15] = empty_now ? '0 : top_reg;
                    out_data_next[78:47] = empty_now ? '0 : bottom_reg;
                    out_data_next[79]    = full_now;
                    out_data_next[80]    = empty_now;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            capacity_reg  <= CAP_W'(CAP_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        bottom_reg   <= bottom_next;
        key_reg      <= key_next;
        scan_reg     <= scan_next;
        ok_reg       <= ok_next;
        found_reg    <= found_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for bounded_stack_with_search_unit: a directed request table, then
// random phases over several capacity settings, checked against a stack predictor or
// hand-written results. Depends on bss_pkg and the unit's RTL only.
module tb_top;
    import bss_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PER_PHASE   = 141;   // random requests per phase, ~1150 in all
    localparam int DRAIN_WAIT  = 80;

    // one result, as it leaves the unit
    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] found_index;
        logic [CNT_W-1:0] count;
        logic [31:0]      top_value;
        logic [31:0]      bottom_value;
        logic             full_res;
        logic             empty_res;
    } stack_result_t;

    // directed table row: either a capacity write or a request, with an optional
    // hand-written result
    typedef struct packed {
        logic             is_cfg;
        logic [CAP_W-1:0] cap;
        kind_t            kind;
        logic [31:0]      value;
        logic             has_want;
        stack_result_t    want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CAP_W-1:0]       cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [WORD_W-1:0]      s_axis_tdata;   // [31:0] value
    logic [KIND_W-1:0]      s_axis_tuser;   // [1:0] kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [0] ok, [7:1] found_index, [14:8] count, [46:15] top_value,
    // [78:47] bottom_value, [79] full_res, [80] empty_res
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    // predictor state: held words, fill count and capacity register
    logic [31:0]      held_words [DEPTH];
    int unsigned      held_count;
    logic [CAP_W-1:0] cap_reg;

    stack_result_t expected_results [$];
    stim_row_t     dir_tab [$];

    bit idle_on = 1'b1;
    int err_count;
    int n_sent;
    int n_dir;
    int n_results;
    int n_cfg;
    int n_hits;
    int n_push_fail;
    int peak_fill;
    int cycles;

    int ph_cap   [PHASES] = '{127, 64, 5, 0, 1, -1, -2, 64};  // -1/-2: random, see below
    int ph_push  [PHASES] = '{75, 30, 45, 40, 45, 50, 50, 55};
    int ph_clear [PHASES] = '{0, 3, 4, 3, 4, 3, 3, 2};

    bounded_stack_with_search_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 expected_results.size());
        $display("bounded_stack_with_search_unit regression: fail");
        $finish;
    end

    // Stack behaviour after one request. Capacity saturates at the built depth;
    // full means count >= capacity, so a capacity of zero, or one lowered under
    // the count, reads as full. Empty stack reports 0 for top and bottom.
    function automatic stack_result_t predict_stack_op(kind_t k, logic [31:0] v);
        stack_result_t r;
        int unsigned   eff;
        eff = (cap_reg > DEPTH) ? DEPTH : cap_reg;
        r.ok          = 1'b1;
        r.found_index = NO_MATCH;
        case (k)
            KIND_PUSH:
            begin
                if (held_count < eff)
                begin
                    held_words[held_count] = v;
                    held_count++;
                end
                else
                begin
                    r.ok = 1'b0;
                    n_push_fail++;
                end
            end
            KIND_POP:
            begin
                if (held_count > 0)
                    held_count--;
                else
                    r.ok = 1'b0;
            end
            KIND_FIND:
            begin
                // first match from the bottom wins
                for (int i = 0; i < held_count; i++)
                    if (r.found_index == NO_MATCH && held_words[i] == v)
                        r.found_index = i[IDX_W-1:0];
                if (r.found_index != NO_MATCH)
                    n_hits++;
            end
            default:
                held_count = 0;   // words stay in place but are never read again
        endcase
        if (held_count > peak_fill)
            peak_fill = held_count;
        r.count        = held_count[CNT_W-1:0];
        r.top_value    = (held_count > 0) ? held_words[held_count-1] : 32'h0;
        r.bottom_value = (held_count > 0) ? held_words[0] : 32'h0;
        r.full_res     = (held_count >= eff);
        r.empty_res    = (held_count == 0);
        return r;
    endfunction

    function automatic stim_row_t op_row(kind_t k, logic [31:0] v);
        stim_row_t row;
        row          = '0;
        row.kind     = k;
        row.value    = v;
        return row;
    endfunction

    function automatic stim_row_t op_chk(kind_t k, logic [31:0] v, logic ok,
                                         logic [IDX_W-1:0] idx, logic [CNT_W-1:0] cnt,
                                         logic [31:0] top, logic [31:0] bot,
                                         logic full, logic empty);
        stim_row_t row;
        row                   = op_row(k, v);
        row.has_want          = 1'b1;
        row.want.ok           = ok;
        row.want.found_index  = idx;
        row.want.count        = cnt;
        row.want.top_value    = top;
        row.want.bottom_value = bot;
        row.want.full_res     = full;
        row.want.empty_res    = empty;
        return row;
    endfunction

    function automatic stim_row_t cap_row(logic [CAP_W-1:0] c);
        stim_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.cap    = c;
        return row;
    endfunction

    // Half random words, the rest extremes and a small pool so that finds see duplicates.
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        int          sel;
        sel = $urandom_range(0, 19);
        if (sel < 10)
            w = $urandom;
        else if (sel < 14)
        begin
            case ($urandom_range(0, 4))
                0:       w = 32'h8000_0000;
                1:       w = 32'h7FFF_FFFF;
                2:       w = 32'hFFFF_FFFF;
                3:       w = 32'h0000_0001;
                default: w = 32'h0000_0000;
            endcase
        end
        else
            w = $urandom_range(0, 15);
        return w;
    endfunction

    function automatic kind_t pick_kind(int push_pct, int clear_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return KIND_PUSH;
        if (r < push_pct + clear_pct)
            return KIND_CLEAR;
        return ($urandom_range(0, 4) < 2) ? KIND_POP : KIND_FIND;
    endfunction

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    task automatic check_result(input stack_result_t got);
        stack_result_t want;
        n_results++;
        if (expected_results.size() == 0)
        begin
            $error("result arrived with no request outstanding");
            err_count++;
            return;
        end
        want = expected_results.pop_front();
        cmp_field("ok", want.ok, got.ok);
        cmp_field("found_index", want.found_index, got.found_index);
        cmp_field("count", want.count, got.count);
        cmp_field("top_value", want.top_value, got.top_value);
        cmp_field("bottom_value", want.bottom_value, got.bottom_value);
        cmp_field("full_res", want.full_res, got.full_res);
        cmp_field("empty_res", want.empty_res, got.empty_res);
    endtask

    // Presents one request and holds it until taken. tvalid is left high on
    // return so back-to-back requests need no second assignment in one step.
    task automatic send_req(input kind_t k, input logic [31:0] v, input logic use_want,
                            input stack_result_t want);
        stack_result_t r;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= k;
        do
            @(posedge clk);
        while (!s_axis_tready);
        n_sent++;
        r = predict_stack_op(k, v);
        expected_results.push_back(use_want ? want : r);
    endtask

    // Stops the request side and waits for every outstanding result.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Capacity is only changed with the unit idle.
    task automatic write_capacity(input logic [CAP_W-1:0] c);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        cap_reg      = c;
        n_cfg++;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result side: check on every handshake, stall in short random bursts.
    initial
    begin
        int            stall;
        stack_result_t got;
        stall = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.ok           = m_axis_tdata[0];
                got.found_index  = m_axis_tdata[7:1];
                got.count        = m_axis_tdata[14:8];
                got.top_value    = m_axis_tdata[46:15];
                got.bottom_value = m_axis_tdata[78:47];
                got.full_res     = m_axis_tdata[79];
                got.empty_res    = m_axis_tdata[80];
                check_result(got);
            end
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        stim_row_t     row;
        kind_t         k;
        logic [31:0]   v;
        int            cap;
        stack_result_t none;

        none           = '0;
        err_count      = 0;
        n_sent         = 0;
        n_results      = 0;
        n_cfg          = 0;
        n_hits         = 0;
        n_push_fail    = 0;
        peak_fill      = 0;
        held_count     = 0;
        cap_reg        = CAP_RESET;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_PUSH;

        // Directed part, capacity 64 from reset.
        // empty stack: pop fails, find misses, clear is harmless
        dir_tab.push_back(op_chk(KIND_POP,   32'h0, 0, NO_MATCH, 0, 32'h0, 32'h0, 0, 1));
        dir_tab.push_back(op_chk(KIND_FIND,  32'h0, 1, NO_MATCH, 0, 32'h0, 32'h0, 0, 1));
        dir_tab.push_back(op_chk(KIND_CLEAR, 32'h0, 1, NO_MATCH, 0, 32'h0, 32'h0, 0, 1));
        // word extremes
        dir_tab.push_back(op_chk(KIND_PUSH, 32'h8000_0000, 1, NO_MATCH, 1,
                                 32'h8000_0000, 32'h8000_0000, 0, 0));
        dir_tab.push_back(op_chk(KIND_PUSH, 32'h7FFF_FFFF, 1, NO_MATCH, 2,
                                 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
        dir_tab.push_back(op_row(KIND_PUSH, 32'hFFFF_FFFF));
        dir_tab.push_back(op_row(KIND_PUSH, 32'h0000_0000));
        dir_tab.push_back(op_chk(KIND_FIND, 32'h7FFF_FFFF, 1, 7'd1, 4,
                                 32'h0, 32'h8000_0000, 0, 0));
        dir_tab.push_back(op_row(KIND_FIND, 32'hFFFF_FFFF));
        dir_tab.push_back(op_row(KIND_FIND, 32'h1234_5678));
        // duplicate: find must report the lower index
        dir_tab.push_back(op_row(KIND_PUSH, 32'h7FFF_FFFF));
        dir_tab.push_back(op_row(KIND_FIND, 32'h7FFF_FFFF));
        dir_tab.push_back(op_row(KIND_POP, 32'h0));
        // capacity lowered under the count: entries kept, reads full, push refused
        dir_tab.push_back(cap_row(7'd2));
        dir_tab.push_back(op_chk(KIND_PUSH, 32'h5555_AAAA, 0, NO_MATCH, 4,
                                 32'h0, 32'h8000_0000, 1, 0));
        dir_tab.push_back(op_row(KIND_POP, 32'h0));
        dir_tab.push_back(op_chk(KIND_CLEAR, 32'h0, 1, NO_MATCH, 0, 32'h0, 32'h0, 0, 1));
        // stale words after clear must not match
        dir_tab.push_back(op_chk(KIND_FIND, 32'h8000_0000, 1, NO_MATCH, 0,
                                 32'h0, 32'h0, 0, 1));
        // capacity zero: full while empty, every push fails
        dir_tab.push_back(cap_row(7'd0));
        dir_tab.push_back(op_chk(KIND_PUSH, 32'h1, 0, NO_MATCH, 0, 32'h0, 32'h0, 1, 1));
        dir_tab.push_back(op_chk(KIND_FIND, 32'h0, 1, NO_MATCH, 0, 32'h0, 32'h0, 1, 1));
        // capacity one: second push hits full
        dir_tab.push_back(cap_row(7'd1));
        dir_tab.push_back(op_chk(KIND_PUSH, 32'hAAAA_5555, 1, NO_MATCH, 1,
                                 32'hAAAA_5555, 32'hAAAA_5555, 1, 0));
        dir_tab.push_back(op_chk(KIND_PUSH, 32'h1, 0, NO_MATCH, 1,
                                 32'hAAAA_5555, 32'hAAAA_5555, 1, 0));
        dir_tab.push_back(op_chk(KIND_POP, 32'h0, 1, NO_MATCH, 0, 32'h0, 32'h0, 0, 1));
        // capacity above depth saturates
        dir_tab.push_back(cap_row(7'd127));
        dir_tab.push_back(op_row(KIND_PUSH, 32'h3));
        dir_tab.push_back(op_row(KIND_FIND, 32'h3));
        dir_tab.push_back(op_row(KIND_CLEAR, 32'h0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            row = dir_tab[i];
            if (row.is_cfg)
                write_capacity(row.cap);
            else
                send_req(row.kind, row.value, row.has_want, row.want);
        end
        n_dir = n_sent;

        // Random phases. The first fills to the built depth, the next drains it;
        // the others mix small, zero, random and lowered capacities.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph_cap[ph] == -1)
                cap = $urandom_range(2, DEPTH - 1);
            else if (ph_cap[ph] == -2)
                cap = $urandom_range(0, 127);
            else
                cap = ph_cap[ph];
            write_capacity(cap[CAP_W-1:0]);
            if (ph == PHASES - 1)
                idle_on = 1'b0;   // closing stretch at full rate
            for (int n = 0; n < PER_PHASE; n++)
            begin
                if (ph == 5 && n == PER_PHASE / 2)
                    drain_results();   // hold off requests until all results are back
                k = pick_kind(ph_push[ph], ph_clear[ph]);
                if (k == KIND_FIND && held_count > 0 && $urandom_range(0, 4) < 3)
                    v = held_words[$urandom_range(0, held_count - 1)];
                else
                    v = pick_word();
                send_req(k, v, 1'b0, none);
            end
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d requests (%0d directed) over %0d capacity writes, %0d results checked",
                 n_sent, n_dir, n_cfg, n_results);
        $display("peak fill %0d of %0d, %0d find hits, %0d refused pushes",
                 peak_fill, DEPTH, n_hits, n_push_fail);
        if (err_count == 0 && expected_results.size() == 0)
            $display("bounded_stack_with_search_unit regression: pass");
        else
            $display("bounded_stack_with_search_unit regression: fail");
        $finish;
    end

endmodule
